FILE: sv/assert_macros.svh
// Assertion macros shared by the capping block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at each rising clock, off while in reset.
`define ASSERT_IMPL(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed");
// Next-cycle implication, off while in reset.
`define ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed");
`endif

FILE: sv/dcc_pkg.sv
// Types and constants of the capping block.
package dcc_pkg;
    localparam logic [1:0] CLS_DUP  = 2'd0;
    localparam logic [1:0] CLS_NEW  = 2'd1;
    localparam logic [1:0] CLS_CAP  = 2'd2;
    localparam logic [1:0] CLS_HIST = 2'd3;
    localparam logic [1:0] REG_TOP  = 2'd0;
    localparam logic [1:0] REG_SEG  = 2'd1;
    localparam logic [1:0] REG_HIST = 2'd2;
    localparam int LEN_W = 17;
    localparam int SEG_W = 27;
    localparam int TOP_W = 7;
    localparam int BYTES_W = 23;
    localparam int FILL_W = 28;
    localparam logic FUNC_END = 1'b1;

    typedef enum logic [2:0] {
        ST_IN, ST_SCAN, ST_LOOK, ST_RANK_START, ST_RANK, ST_EMIT_RD, ST_EMIT
    } t_state;

    // Queue word between the front and the core.
    typedef struct packed {
        logic              flush;
        logic [63:0]       id;
        logic [1:0]        cls;
        logic [LEN_W-1:0]  len;
    } t_cmd;
endpackage

FILE: sv/dcc_front.sv
// Front: classifies incoming words and queues them for the core.
module dcc_front #(
    parameter int ID_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  logic              i_func,
    input  logic [31:0]       i_container_id,
    input  logic              i_is_new,
    input  logic              i_in_sparse_history,
    input  logic [16:0]       i_chunk_length,
    input  logic              i_hist_mode,
    output logic              o_q_valid,
    output dcc_pkg::t_cmd     o_q_cmd,
    input  logic              i_q_take
);
    dcc_pkg::t_cmd r_q [2];
    logic [1:0] r_cnt, n_cnt;
    logic r_rd, r_wr;
    dcc_pkg::t_cmd n_cmd;
    logic [63:0] w_id;
    logic w_push;

    always_comb begin
        w_id = 64'(i_container_id);
        if (ID_BITS < 64) begin
            w_id = w_id & ((64'd1 << ID_BITS) - 64'd1);
        end
        n_cmd.flush = (i_func == dcc_pkg::FUNC_END);
        n_cmd.id = w_id;
        n_cmd.len = i_chunk_length;
        if (i_is_new) n_cmd.cls = dcc_pkg::CLS_NEW;
        else if (i_hist_mode && i_in_sparse_history) n_cmd.cls = dcc_pkg::CLS_HIST;
        else n_cmd.cls = dcc_pkg::CLS_DUP;
    end

    assign o_full = (r_cnt == 2'd2);
    assign w_push = i_push && !o_full;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_cmd = r_q[r_rd];

    always_comb begin
        n_cnt = r_cnt + 2'(w_push) - 2'(i_q_take && o_q_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd <= 1'b0;
            r_wr <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) r_wr <= !r_wr;
            if (i_q_take && o_q_valid) r_rd <= !r_rd;
        end
        if (w_push) r_q[r_wr] <= n_cmd;
    end
endmodule

FILE: sv/dcc_core.sv
// Core: container table update, segment ranking and verdict emission.
module dcc_core #(
    parameter int MAX_CHUNKS = 64,
    parameter int ID_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  dcc_pkg::t_cmd     i_q_cmd,
    output logic              o_q_take,
    input  logic [6:0]        i_top,
    input  logic [26:0]       i_seg,
    output logic              o_empty,
    input  logic              i_pop,
    output logic [31:0]       o_container_id_res,
    output logic [16:0]       o_chunk_length_res,
    output logic [1:0]        o_verdict,
    output logic              o_last
);
    localparam int AW = $clog2(MAX_CHUNKS);
    localparam int CW = $clog2(MAX_CHUNKS + 1);

    dcc_pkg::t_state r_st, n_st;
    logic [ID_BITS-1:0] r_bid [MAX_CHUNKS];
    logic [16:0] r_blen [MAX_CHUNKS];
    logic [1:0] r_bcls [MAX_CHUNKS];
    logic [AW-1:0] r_bidx [MAX_CHUNKS];
    logic [ID_BITS-1:0] r_tid [MAX_CHUNKS];
    logic [22:0] r_tby [MAX_CHUNKS];
    logic [MAX_CHUNKS-1:0] r_kept;
    logic [CW-1:0] r_tcnt, r_ccnt, r_i, r_j;
    logic [27:0] r_fill;
    logic r_pend;
    logic [AW-1:0] r_hidx;
    logic [ID_BITS-1:0] r_kid, r_cid;
    logic [22:0] r_kby, r_cby;
    logic [6:0] r_beat;
    logic [ID_BITS-1:0] r_eid;
    logic [16:0] r_elen;
    logic [1:0] r_ecls;
    logic [AW-1:0] r_eidx;
    logic r_ov;
    logic [31:0] r_oid;
    logic [16:0] r_olen;
    logic [1:0] r_over;
    logic r_olast;

    logic [ID_BITS-1:0] w_qid;
    logic w_close;
    logic w_beats;
    logic w_hit;
    logic w_last_j;
    logic [AW-1:0] w_ia, w_jn;

    assign w_qid = i_q_cmd.id[ID_BITS-1:0];
    assign w_ia = r_i[AW-1:0];
    assign w_jn = AW'(r_j + CW'(1));
    assign w_last_j = (r_j + CW'(1) >= r_tcnt);
    assign w_hit = (r_cid == w_qid);

    assign w_close = i_q_cmd.flush ? (r_ccnt != '0)
        : ((r_ccnt != '0) && ((r_fill + 28'(i_q_cmd.len) > 28'(i_seg))
            || (r_ccnt >= CW'(MAX_CHUNKS))));
    assign w_beats = (r_cby > r_kby) || ((r_cby == r_kby) && (r_cid > r_kid));

    assign o_empty = !r_ov;
    assign o_container_id_res = r_oid;
    assign o_chunk_length_res = r_olen;
    assign o_verdict = r_over;
    assign o_last = r_olast;

    always_comb begin
        n_st = r_st;
        o_q_take = 1'b0;
        case (r_st)
            dcc_pkg::ST_IN: begin
                if (i_q_valid) begin
                    if (w_close) n_st = dcc_pkg::ST_RANK_START;
                    else if (i_q_cmd.flush) o_q_take = 1'b1;
                    else if (i_q_cmd.cls == dcc_pkg::CLS_DUP && r_tcnt != '0)
                        n_st = dcc_pkg::ST_SCAN;
                    else n_st = dcc_pkg::ST_LOOK;
                end
            end
            dcc_pkg::ST_SCAN: begin
                if (w_hit || w_last_j) n_st = dcc_pkg::ST_LOOK;
            end
            dcc_pkg::ST_LOOK: begin
                o_q_take = 1'b1;
                n_st = dcc_pkg::ST_IN;
            end
            dcc_pkg::ST_RANK_START: begin
                n_st = (r_i >= r_tcnt) ? dcc_pkg::ST_EMIT_RD : dcc_pkg::ST_RANK;
            end
            dcc_pkg::ST_RANK: begin
                if (w_last_j) n_st = dcc_pkg::ST_RANK_START;
            end
            dcc_pkg::ST_EMIT_RD: begin
                if (r_i >= r_ccnt) begin
                    n_st = dcc_pkg::ST_IN;
                    if (i_q_cmd.flush) o_q_take = 1'b1;
                end else begin
                    n_st = dcc_pkg::ST_EMIT;
                end
            end
            dcc_pkg::ST_EMIT: begin
                if (!r_ov || i_pop) n_st = dcc_pkg::ST_EMIT_RD;
            end
            default: n_st = dcc_pkg::ST_IN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= dcc_pkg::ST_IN;
            r_tcnt <= '0;
            r_ccnt <= '0;
            r_fill <= '0;
            r_ov <= 1'b0;
            r_i <= '0;
            r_j <= '0;
            r_pend <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_st == dcc_pkg::ST_EMIT && (!r_ov || i_pop)) r_ov <= 1'b1;
            else if (r_ov && i_pop) r_ov <= 1'b0;
            case (r_st)
                dcc_pkg::ST_IN: begin
                    r_i <= '0;
                    r_j <= '0;
                    r_pend <= 1'b0;
                    r_cid <= r_tid[0];
                    r_cby <= r_tby[0];
                end
                dcc_pkg::ST_SCAN: begin
                    if (w_hit) begin
                        r_pend <= 1'b1;
                        r_hidx <= r_j[AW-1:0];
                    end else if (!w_last_j) begin
                        r_j <= r_j + CW'(1);
                        r_cid <= r_tid[w_jn];
                        r_cby <= r_tby[w_jn];
                    end
                end
                dcc_pkg::ST_LOOK: begin
                    if (i_q_cmd.cls == dcc_pkg::CLS_DUP) begin
                        if (r_pend) begin
                            r_tby[r_hidx] <= r_cby + 23'(i_q_cmd.len);
                            r_bidx[r_ccnt[AW-1:0]] <= r_hidx;
                        end else begin
                            r_tid[r_tcnt[AW-1:0]] <= w_qid;
                            r_tby[r_tcnt[AW-1:0]] <= 23'(i_q_cmd.len);
                            r_bidx[r_ccnt[AW-1:0]] <= r_tcnt[AW-1:0];
                            r_tcnt <= r_tcnt + CW'(1);
                        end
                    end
                    r_bid[r_ccnt[AW-1:0]] <= w_qid;
                    r_blen[r_ccnt[AW-1:0]] <= i_q_cmd.len;
                    r_bcls[r_ccnt[AW-1:0]] <= i_q_cmd.cls;
                    r_ccnt <= r_ccnt + CW'(1);
                    r_fill <= r_fill + 28'(i_q_cmd.len);
                end
                dcc_pkg::ST_RANK_START: begin
                    r_j <= '0;
                    r_beat <= '0;
                    if (r_i >= r_tcnt) begin
                        r_i <= '0;
                    end else begin
                        r_kid <= r_tid[w_ia];
                        r_kby <= r_tby[w_ia];
                        r_cid <= r_tid[0];
                        r_cby <= r_tby[0];
                    end
                end
                dcc_pkg::ST_RANK: begin
                    if (w_last_j) begin
                        r_kept[w_ia] <= (7'(r_beat + 7'(w_beats)) < i_top);
                        r_i <= r_i + CW'(1);
                    end else begin
                        r_beat <= r_beat + 7'(w_beats);
                        r_j <= r_j + CW'(1);
                        r_cid <= r_tid[w_jn];
                        r_cby <= r_tby[w_jn];
                    end
                end
                dcc_pkg::ST_EMIT_RD: begin
                    if (r_i >= r_ccnt) begin
                        r_ccnt <= '0;
                        r_tcnt <= '0;
                        r_fill <= '0;
                    end else begin
                        r_eid <= r_bid[w_ia];
                        r_elen <= r_blen[w_ia];
                        r_ecls <= r_bcls[w_ia];
                        r_eidx <= r_bidx[w_ia];
                    end
                end
                dcc_pkg::ST_EMIT: begin
                    if (!r_ov || i_pop) begin
                        r_oid <= 32'(r_eid);
                        r_olen <= r_elen;
                        r_olast <= (r_i + CW'(1) == r_ccnt);
                        r_i <= r_i + CW'(1);
                        if (r_ecls == dcc_pkg::CLS_DUP)
                            r_over <= r_kept[r_eidx] ? dcc_pkg::CLS_DUP : dcc_pkg::CLS_CAP;
                        else
                            r_over <= r_ecls;
                    end
                end
                default: ;
            endcase
        end
    end

    logic w_unused;
    assign w_unused = ^i_q_cmd.id;
endmodule

FILE: sv/dedup_container_capping_core.sv
// Top level of the container capping rewrite decision block.
// A two-entry input queue feeds the core. Each chunk is first classified, then
// used to update the table and buffer; a duplicate also scans the container
// table one entry per cycle up to its match. Closing a segment ranks the
// containers through one comparator, then emits the chunks one by one, each read
// from the buffer and then output, holding while the receiver does not pop;
// input stalls during that time.
`include "assert_macros.svh"
module dedup_container_capping_core #(
    parameter int MAX_CHUNKS = 64,
    parameter int ID_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_func,
    input  logic [31:0] i_container_id,
    input  logic        i_is_new,
    input  logic        i_in_sparse_history,
    input  logic [16:0] i_chunk_length,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_container_id_res,
    output logic [16:0] o_chunk_length_res,
    output logic [1:0]  o_verdict,
    output logic        o_last,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [26:0] i_cfg_data
);
    logic [6:0] r_top;
    logic [26:0] r_seg;
    logic r_hist;
    logic w_qv, w_take;
    dcc_pkg::t_cmd w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top <= 7'd16;
            r_seg <= 27'd4194304;
            r_hist <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                dcc_pkg::REG_TOP:  r_top <= i_cfg_data[6:0];
                dcc_pkg::REG_SEG:  r_seg <= i_cfg_data;
                dcc_pkg::REG_HIST: r_hist <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    dcc_front #(.ID_BITS(ID_BITS)) u_front (
        .i_clk, .i_rst_n, .i_push(push), .o_full(full), .i_func,
        .i_container_id, .i_is_new, .i_in_sparse_history, .i_chunk_length,
        .i_hist_mode(r_hist), .o_q_valid(w_qv), .o_q_cmd(w_cmd), .i_q_take(w_take)
    );

    dcc_core #(.MAX_CHUNKS(MAX_CHUNKS), .ID_BITS(ID_BITS)) u_core (
        .i_clk, .i_rst_n, .i_q_valid(w_qv), .i_q_cmd(w_cmd), .o_q_take(w_take),
        .i_top(r_top), .i_seg(r_seg), .o_empty(empty), .i_pop(pop),
        .o_container_id_res, .o_chunk_length_res, .o_verdict, .o_last
    );

    `ASSERT_IMPL(a_take_valid, i_clk, i_rst_n, w_take, w_qv)
    `ASSERT_NEXT(a_hold_out, i_clk, i_rst_n, !empty && !pop,
        !empty && $stable(o_container_id_res))
endmodule

FILE: tb/tb_dedup_container_capping_core.sv
// Testbench for the container capping core: directed and random chunk streams checked against a predictor.
`timescale 1ns / 1ps
module tb_dedup_container_capping_core;

    localparam int SLOTS = 64;
    localparam int LIMIT_CYCLES = 600000;
    localparam int SETTLE_CYCLES = 64;

    typedef struct {
        logic [31:0]               id;
        logic [dcc_pkg::LEN_W-1:0] len;
        logic [1:0]                verdict;
        logic                      last;
    } t_chunk_out;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              push = 1'b0;
    logic              full;
    logic              i_func = 1'b0;
    logic [31:0]       i_container_id = '0;
    logic              i_is_new = 1'b0;
    logic              i_in_sparse_history = 1'b0;
    logic [16:0]       i_chunk_length = '0;
    logic              empty;
    logic              pop = 1'b0;
    logic [31:0]       o_container_id_res;
    logic [16:0]       o_chunk_length_res;
    logic [1:0]        o_verdict;
    logic              o_last;
    logic              i_cfg_we = 1'b0;
    logic [1:0]        i_cfg_index = '0;
    logic [26:0]       i_cfg_data = '0;

    // predictor state
    logic [dcc_pkg::TOP_W-1:0]   cap_top;
    logic [dcc_pkg::SEG_W-1:0]   cap_seg;
    logic                        cap_hist;
    logic [31:0]                 seg_ids [SLOTS];
    logic [dcc_pkg::LEN_W-1:0]   seg_lens [SLOTS];
    logic [1:0]                  seg_cls [SLOTS];
    logic [31:0]                 ctr_ids [SLOTS];
    logic [dcc_pkg::BYTES_W-1:0] ctr_bytes [SLOTS];
    int                          ctr_count;
    int                          seg_count;
    longint                      seg_fill;

    t_chunk_out expected_chunks[$];
    int  errors = 0;
    int  cycles = 0;
    bit  quiet = 1'b0;
    int  hold_off = 0;
    int  pop_gap = 0;

    dedup_container_capping_core dut (.*);

    always #2 i_clk = ~i_clk;

    function automatic bit container_kept(logic [31:0] id);
        int k;
        int beaten;
        k = -1;
        beaten = 0;
        for (int i = 0; i < ctr_count; i++)
            if (k < 0 && ctr_ids[i] == id) k = i;
        if (k < 0) return 1'b0;
        for (int j = 0; j < ctr_count; j++)
            if (ctr_bytes[j] > ctr_bytes[k] ||
                (ctr_bytes[j] == ctr_bytes[k] && ctr_ids[j] > ctr_ids[k]))
                beaten++;
        return beaten < cap_top;
    endfunction

    task automatic close_segment();
        t_chunk_out w;
        for (int i = 0; i < seg_count; i++) begin
            w.id = seg_ids[i];
            w.len = seg_lens[i];
            if (seg_cls[i] == dcc_pkg::CLS_NEW) w.verdict = dcc_pkg::CLS_NEW;
            else if (seg_cls[i] == dcc_pkg::CLS_HIST) w.verdict = dcc_pkg::CLS_HIST;
            else w.verdict = container_kept(seg_ids[i]) ? dcc_pkg::CLS_DUP : dcc_pkg::CLS_CAP;
            w.last = (i + 1 == seg_count);
            expected_chunks.push_back(w);
        end
        seg_count = 0;
        ctr_count = 0;
        seg_fill = 0;
    endtask

    task automatic predict_word(logic fn, logic [31:0] id, logic nw, logic sp,
                                logic [dcc_pkg::LEN_W-1:0] len);
        logic [1:0] cls;
        bit found;
        found = 1'b0;
        if (fn == dcc_pkg::FUNC_END) begin
            close_segment();
            return;
        end
        if (seg_count > 0 && (seg_fill + len > cap_seg || seg_count >= SLOTS))
            close_segment();
        if (seg_count >= SLOTS) return;
        cls = nw ? dcc_pkg::CLS_NEW
            : ((cap_hist && sp) ? dcc_pkg::CLS_HIST : dcc_pkg::CLS_DUP);
        if (cls == dcc_pkg::CLS_DUP) begin
            for (int i = 0; i < ctr_count; i++)
                if (!found && ctr_ids[i] == id) begin
                    ctr_bytes[i] = ctr_bytes[i] + len;
                    found = 1'b1;
                end
            if (!found && ctr_count < SLOTS) begin
                ctr_ids[ctr_count] = id;
                ctr_bytes[ctr_count] = len;
                ctr_count++;
            end
        end
        seg_ids[seg_count] = id;
        seg_lens[seg_count] = len;
        seg_cls[seg_count] = cls;
        seg_count++;
        seg_fill += len;
    endtask

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("%0t timeout", $time);
            $display("tb_dedup_container_capping_core failed");
            $finish;
        end
        if (!i_rst_n) begin
            cap_top = 16;
            cap_seg = 4194304;
            cap_hist = 1'b0;
            seg_count = 0;
            ctr_count = 0;
            seg_fill = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    dcc_pkg::REG_TOP:  cap_top = i_cfg_data[dcc_pkg::TOP_W-1:0];
                    dcc_pkg::REG_SEG:  cap_seg = i_cfg_data[dcc_pkg::SEG_W-1:0];
                    dcc_pkg::REG_HIST: cap_hist = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (push && !full)
                predict_word(i_func, i_container_id, i_is_new, i_in_sparse_history,
                             i_chunk_length);
            if (pop && !empty) begin
                if (expected_chunks.size() == 0) begin
                    errors++;
                    $display("%0t unexpected word id=%h len=%0d verdict=%0d last=%b",
                             $time, o_container_id_res, o_chunk_length_res, o_verdict,
                             o_last);
                end else begin
                    t_chunk_out w;
                    w = expected_chunks.pop_front();
                    if (o_container_id_res !== w.id || o_chunk_length_res !== w.len ||
                        o_verdict !== w.verdict || o_last !== w.last) begin
                        errors++;
                        $display("%0t mismatch exp id=%h len=%0d verdict=%0d last=%b",
                                 $time, w.id, w.len, w.verdict, w.last);
                        $display("%0t          got id=%h len=%0d verdict=%0d last=%b",
                                 $time, o_container_id_res, o_chunk_length_res, o_verdict,
                                 o_last);
                    end
                end
            end
        end
    end

    // receiver: random stalls and a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            hold_off--;
            pop = 1'b0;
        end else if (pop_gap > 0) begin
            pop_gap--;
            pop = 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            pop_gap = $urandom_range(0, 7);
            pop = 1'b0;
        end else begin
            pop = 1'b1;
        end
    end

    task automatic send_word(logic fn, logic [31:0] id, logic nw, logic sp,
                             logic [16:0] len);
        if (!quiet && $urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        push = 1'b1;
        i_func = fn;
        i_container_id = id;
        i_is_new = nw;
        i_in_sparse_history = sp;
        i_chunk_length = len;
        do @(posedge i_clk); while (full !== 1'b0);
        @(negedge i_clk);
        push = 1'b0;
    endtask

    task automatic send_chunk(logic [31:0] id, logic nw, logic sp, logic [16:0] len);
        send_word(1'b0, id, nw, sp, len);
    endtask

    task automatic end_stream();
        send_word(dcc_pkg::FUNC_END, $urandom, 1'($urandom), 1'($urandom), 17'($urandom));
    endtask

    task automatic wait_drained();
        while (expected_chunks.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [26:0] data);
        wait_drained();
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic test_directed();
        // kept, new, sparse ignored with history off, zero length and length 65536
        send_chunk(32'h0, 1'b0, 1'b0, 17'd0);
        send_chunk(32'hFFFF_FFFF, 1'b0, 1'b1, 17'd65536);
        send_chunk(32'h1234_5678, 1'b1, 1'b1, 17'd1);
        end_stream();
        end_stream();
        // ties keep the higher id, then capping rewrites the rest
        write_reg(dcc_pkg::REG_TOP, 27'd1);
        write_reg(dcc_pkg::REG_HIST, 27'd1);
        send_chunk(32'd5, 1'b0, 1'b0, 17'd100);
        send_chunk(32'd9, 1'b0, 1'b0, 17'd100);
        send_chunk(32'd7, 1'b0, 1'b1, 17'd500);
        send_chunk(32'd3, 1'b1, 1'b1, 17'd500);
        end_stream();
        // no container kept
        write_reg(dcc_pkg::REG_TOP, 27'd0);
        send_chunk(32'd1, 1'b0, 1'b0, 17'd10);
        send_chunk(32'd2, 1'b0, 1'b0, 17'd20);
        end_stream();
        // small segment: overflow close and oversize repair
        write_reg(dcc_pkg::REG_TOP, 27'd64);
        write_reg(dcc_pkg::REG_SEG, 27'd1);
        send_chunk(32'd4, 1'b0, 1'b0, 17'd1);
        send_chunk(32'd4, 1'b0, 1'b0, 17'd1);
        send_chunk(32'd6, 1'b0, 1'b0, 17'd65536);
        send_chunk(32'd8, 1'b0, 1'b0, 17'd0);
        end_stream();
        write_reg(dcc_pkg::REG_SEG, 27'd67108864);
        send_chunk(32'd8, 1'b0, 1'b0, 17'd3);
        end_stream();
    endtask

    task automatic test_full_segment();
        // 64 distinct containers fill the buffer; the 65th closes it
        write_reg(dcc_pkg::REG_TOP, 27'd20);
        write_reg(dcc_pkg::REG_HIST, 27'd0);
        for (int i = 0; i < 65; i++)
            send_chunk($urandom, 1'b0, 1'b0, 17'($urandom_range(1, 5000)));
        end_stream();
    endtask

    task automatic rand_chunk(logic [31:0] base);
        logic [31:0] id;
        logic [16:0] len;
        int r;
        r = $urandom_range(0, 99);
        id = (r < 5) ? $urandom : base + $urandom_range(0, 7);
        len = ($urandom_range(0, 3) != 0) ? 17'($urandom_range(1, 4096))
            : 17'($urandom_range(0, 65536));
        if (r >= 97) end_stream();
        else send_chunk(id, $urandom_range(0, 9) == 0, 1'($urandom), len);
    endtask

    task automatic test_backpressure();
        logic [31:0] base;
        base = $urandom;
        write_reg(dcc_pkg::REG_SEG, 27'd20000);
        hold_off = 400;
        for (int i = 0; i < 50; i++) rand_chunk(base);
        end_stream();
        wait_drained();
        // sender pauses until everything has come back
        for (int i = 0; i < 10; i++) rand_chunk(base);
        end_stream();
        wait_drained();
    endtask

    task automatic test_random();
        logic [26:0] segs [4];
        logic [31:0] base;
        segs = '{27'd20000, 27'd100000, 27'd4194304, 27'd67108864};
        for (int p = 0; p < 4; p++) begin
            write_reg(dcc_pkg::REG_TOP, 27'($urandom_range(0, 9)));
            write_reg(dcc_pkg::REG_SEG, segs[p]);
            write_reg(dcc_pkg::REG_HIST, 27'($urandom_range(0, 1)));
            base = $urandom;
            if (p == 3) quiet = 1'b1;
            for (int i = 0; i < 80; i++) rand_chunk(base);
            end_stream();
        end
    endtask

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        test_directed();
        test_full_segment();
        test_backpressure();
        test_random();
        wait_drained();
        if (errors == 0)
            $display("tb_dedup_container_capping_core passed");
        else
            $display("tb_dedup_container_capping_core failed");
        $finish;
    end
endmodule
